[src/teu_pkg.sv]
// Shared types and constants for the trap entry unit.
package teu_pkg;

	// Default number of register windows.
	localparam int NUM_WINDOWS_DEF = 8;

	// Register field positions.
	localparam int PSR_ET_BIT   = 5;
	localparam int PSR_PS_BIT   = 6;
	localparam int PSR_S_BIT    = 7;
	localparam int FSR_FTT_LSB  = 14;
	localparam int FSR_AEXC_LSB = 5;
	localparam int FSR_TEM_LSB  = 23;

	// Mask that clears the TT field of the TBR.
	localparam logic [31:0] TBR_TT_CLEAR  = 32'hFFFF_F00F;
	// Mask that clears the FTT field of the FSR.
	localparam logic [31:0] FSR_FTT_CLEAR = 32'hFFFE_3FFF;
	// Floating-point trap type for an IEEE exception.
	localparam logic [2:0]  FTT_IEEE      = 3'd1;
	// Distance from the handler entry to the next instruction.
	localparam logic [31:0] INSN_BYTES    = 32'd4;

	// Operation codes.
	typedef enum logic [1:0] {
		OP_INT_TRAP  = 2'd0,
		OP_FP_CHECK  = 2'd1,
		OP_FP_TRAP   = 2'd2,
		OP_SET_ERROR = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_NO_TRAP = 2'd0,
		ST_TRAP    = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	// One request as held in the input stage.
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  trap_type;
		logic [2:0]  ftt_code;
		logic [4:0]  fp_flags;
		logic [31:0] cur_psr;
		logic [31:0] cur_tbr;
		logic [31:0] cur_fsr;
		logic [31:0] cur_pc;
		logic [31:0] cur_npc;
		logic        new_error_mode;
	} item_t;

	// One result as held in the output stage.
	typedef struct packed {
		logic [1:0]  status;
		logic        error_mode;
		logic [31:0] next_psr;
		logic [31:0] next_tbr;
		logic [31:0] next_fsr;
		logic [31:0] next_pc;
		logic [31:0] next_npc;
		logic [31:0] saved_pc;
		logic [31:0] saved_npc;
	} result_t;

endpackage

[src/teu_req_if.sv]
// Request channel of the trap entry unit.
interface teu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  trap_type;
	logic [2:0]  ftt_code;
	logic [4:0]  fp_flags;
	logic [31:0] cur_psr;
	logic [31:0] cur_tbr;
	logic [31:0] cur_fsr;
	logic [31:0] cur_pc;
	logic [31:0] cur_npc;
	logic        new_error_mode;

	modport source (
		output valid, op, trap_type, ftt_code, fp_flags, cur_psr, cur_tbr,
		       cur_fsr, cur_pc, cur_npc, new_error_mode,
		input  ready
	);
	modport sink (
		input  valid, op, trap_type, ftt_code, fp_flags, cur_psr, cur_tbr,
		       cur_fsr, cur_pc, cur_npc, new_error_mode,
		output ready
	);
endinterface

[src/teu_rsp_if.sv]
// Result channel of the trap entry unit.
interface teu_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        error_mode;
	logic [31:0] next_psr;
	logic [31:0] next_tbr;
	logic [31:0] next_fsr;
	logic [31:0] next_pc;
	logic [31:0] next_npc;
	logic [31:0] saved_pc;
	logic [31:0] saved_npc;

	modport source (
		output valid, status, error_mode, next_psr, next_tbr, next_fsr,
		       next_pc, next_npc, saved_pc, saved_npc,
		input  ready
	);
	modport sink (
		input  valid, status, error_mode, next_psr, next_tbr, next_fsr,
		       next_pc, next_npc, saved_pc, saved_npc,
		output ready
	);
endinterface

[src/trap_entry_unit_core.sv]
// Top level of the trap entry unit: input stage, computation and result stage.
// A request accepted into the input stage moves on to the result stage when the result stage advances.
// Throughput: one request per cycle while results are taken, set by the single input and result stage pair.
// The result stage advances when the input stage holds a request and it is empty or its result is taken.
// Reset clears both stage valid bits and the error mode flag; no clearing pass.
module trap_entry_unit_core #(
	parameter int NUM_WINDOWS = teu_pkg::NUM_WINDOWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	teu_req_if.sink   req,
	teu_rsp_if.source rsp
);
	import teu_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    error_mode_q;
	result_t res_calc;
	logic    em_calc;
	logic    adv_s2;
	logic    take_s1;

	// Flow control between the two stages.
	assign adv_s2  = valid_s1 && (!valid_s2 || rsp.ready);
	assign take_s1 = req.valid && req.ready;
	assign req.ready = !valid_s1 || adv_s2;

	// Input stage holds the accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1 <= '{op: req.op, trap_type: req.trap_type, ftt_code: req.ftt_code,
				fp_flags: req.fp_flags, cur_psr: req.cur_psr, cur_tbr: req.cur_tbr,
				cur_fsr: req.cur_fsr, cur_pc: req.cur_pc, cur_npc: req.cur_npc,
				new_error_mode: req.new_error_mode};
		end
	end

	teu_calc #(
		.NUM_WINDOWS(NUM_WINDOWS)
	) u_calc (
		.item           (item_s1),
		.error_mode_cur (error_mode_q),
		.result         (res_calc),
		.error_mode_nxt (em_calc)
	);

	// Result stage and error mode flag advance together, in request order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			error_mode_q <= 1'b0;
		end else begin
			if (adv_s2) begin
				error_mode_q <= em_calc;
				valid_s2     <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_calc;
		end
	end

	// Drive the result channel.
	assign rsp.valid      = valid_s2;
	assign rsp.status     = res_s2.status;
	assign rsp.error_mode = res_s2.error_mode;
	assign rsp.next_psr   = res_s2.next_psr;
	assign rsp.next_tbr   = res_s2.next_tbr;
	assign rsp.next_fsr   = res_s2.next_fsr;
	assign rsp.next_pc    = res_s2.next_pc;
	assign rsp.next_npc   = res_s2.next_npc;
	assign rsp.saved_pc   = res_s2.saved_pc;
	assign rsp.saved_npc  = res_s2.saved_npc;
endmodule

[src/teu_calc.sv]
// Combinational trap entry computation for one request.
module teu_calc #(
	parameter int NUM_WINDOWS = teu_pkg::NUM_WINDOWS_DEF
) (
	input  teu_pkg::item_t   item,
	input  logic             error_mode_cur,
	output teu_pkg::result_t result,
	output logic             error_mode_nxt
);
	import teu_pkg::*;

	logic [4:0]  cwp_dec [32];
	logic [4:0]  tem;
	logic [31:0] fsr_upd;
	logic        want_trap;
	logic [2:0]  trap_ftt;
	logic        em_op;
	logic [31:0] tbr_trap;
	logic [31:0] psr_trap;

	// Table of the decremented window pointer, reduced modulo the window count.
	for (genvar i = 0; i < 32; i++) begin : g_cwp
		assign cwp_dec[i] = 5'((i % NUM_WINDOWS + NUM_WINDOWS - 1) % NUM_WINDOWS);
	end

	assign tem = item.cur_fsr[FSR_TEM_LSB +: 5];

	// Decode the operation and update the exception fields of the FSR.
	always_comb begin
		fsr_upd   = item.cur_fsr;
		want_trap = 1'b0;
		trap_ftt  = '0;
		em_op     = error_mode_cur;
		case (op_t'(item.op))
			OP_INT_TRAP: begin
				want_trap = 1'b1;
			end
			OP_FP_CHECK: begin
				fsr_upd[4:0] = item.fp_flags;
				if ((tem & item.fp_flags) != 5'd0) begin
					want_trap = 1'b1;
					trap_ftt  = FTT_IEEE;
				end else begin
					fsr_upd[FSR_AEXC_LSB +: 5] = item.cur_fsr[FSR_AEXC_LSB +: 5] |
						item.fp_flags;
				end
			end
			OP_FP_TRAP: begin
				fsr_upd[4:0] = item.cur_fsr[4:0] | item.fp_flags;
				want_trap    = 1'b1;
				trap_ftt     = item.ftt_code;
			end
			default: begin
				em_op = item.new_error_mode;
			end
		endcase
	end

	// Register values after a taken trap.
	always_comb begin
		tbr_trap = (item.cur_tbr & TBR_TT_CLEAR) | {20'd0, item.trap_type, 4'd0};
		psr_trap = {item.cur_psr[31:8], 8'd0};
		psr_trap[4:0]       = cwp_dec[item.cur_psr[4:0]];
		psr_trap[PSR_PS_BIT] = item.cur_psr[PSR_S_BIT];
		psr_trap[PSR_S_BIT]  = 1'b1;
	end

	// Select between no trap, a taken trap and entry into error mode.
	always_comb begin
		result.status     = ST_NO_TRAP;
		result.next_psr   = item.cur_psr;
		result.next_tbr   = item.cur_tbr;
		result.next_fsr   = fsr_upd;
		result.next_pc    = item.cur_pc;
		result.next_npc   = item.cur_npc;
		result.saved_pc   = '0;
		result.saved_npc  = '0;
		error_mode_nxt    = em_op;
		if (want_trap) begin
			if (!item.cur_psr[PSR_ET_BIT]) begin
				result.status  = ST_ERROR;
				error_mode_nxt = 1'b1;
			end else begin
				result.status    = ST_TRAP;
				result.next_psr  = psr_trap;
				result.next_tbr  = tbr_trap;
				result.next_pc   = tbr_trap;
				result.next_npc  = tbr_trap + INSN_BYTES;
				result.saved_pc  = item.cur_pc;
				result.saved_npc = item.cur_npc;
				if (op_t'(item.op) != OP_INT_TRAP) begin
					result.next_fsr = (fsr_upd & FSR_FTT_CLEAR) |
						{15'd0, trap_ftt, 14'd0};
				end
			end
		end
		result.error_mode = error_mode_nxt;
	end
endmodule

[src/teu_checker.sv]
// Port-level checks of the trap entry unit and their binding to the top level.
module teu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic [1:0]  status,
	input logic        error_mode,
	input logic [31:0] next_psr,
	input logic [31:0] next_pc,
	input logic [31:0] next_npc,
	input logic [31:0] saved_pc,
	input logic [31:0] saved_npc
);
	import teu_pkg::*;

	// Status is one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_NO_TRAP || status == ST_TRAP || status == ST_ERROR))
		else $error("undefined status code");

	// A taken trap sends nPC four bytes past PC.
	a_trap_npc: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_TRAP) |-> (next_npc == next_pc + 32'd4))
		else $error("trap nPC is not PC plus four");

	// A taken trap leaves traps disabled and supervisor mode set.
	a_trap_psr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_TRAP) |-> (!next_psr[5] && next_psr[7]))
		else $error("trap PSR has wrong ET or S");

	// Entering error mode always reports the flag set.
	a_error_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_ERROR) |-> error_mode)
		else $error("error mode entered without flag");

	// Saved PC and nPC are zero unless a trap is taken.
	a_saved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_TRAP) |-> (saved_pc == 32'd0 && saved_npc == 32'd0))
		else $error("saved values without a taken trap");
endmodule

bind trap_entry_unit_core teu_checker u_teu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.status     (rsp.status),
	.error_mode (rsp.error_mode),
	.next_psr   (rsp.next_psr),
	.next_pc    (rsp.next_pc),
	.next_npc   (rsp.next_npc),
	.saved_pc   (rsp.saved_pc),
	.saved_npc  (rsp.saved_npc)
);
